FILE: hw/rtl/stf_pkg.sv
// shared types, format codes and helpers for the sample to float converter
package stf_pkg;

   localparam logic [3:0] FMT_F32 = 4'd0;
   localparam logic [3:0] FMT_F64 = 4'd1;
   localparam logic [3:0] FMT_U8  = 4'd2;
   localparam logic [3:0] FMT_U16 = 4'd3;
   localparam logic [3:0] FMT_U32 = 4'd4;
   localparam logic [3:0] FMT_U64 = 4'd5;
   localparam logic [3:0] FMT_S8  = 4'd6;
   localparam logic [3:0] FMT_S16 = 4'd7;
   localparam logic [3:0] FMT_S32 = 4'd8;
   localparam logic [3:0] FMT_S64 = 4'd9;

   localparam logic [1:0] CSR_FMT_SEL       = 2'd0;
   localparam logic [1:0] CSR_SWAP_BYTES    = 2'd1;
   localparam logic [1:0] CSR_OUTPUT_DOUBLE = 2'd2;

   typedef struct packed {
      logic [63:0] sample_word;
      logic        last_in;
   } req_type;

   typedef struct packed {
      logic [63:0] float_bits;
      logic        last_out;
   } rsp_type;

   typedef struct packed {
      logic [3:0] fmt_sel;
      logic       swap_bytes;
      logic       output_double;
   } cfg_type;

   // stage 1 to stage 2: normalized significand source
   typedef struct packed {
      logic        dbl;
      logic        sign;
      logic [63:0] mag;     // integer magnitude, f64/f32 significand
      logic [12:0] ex;      // signed exponent of bit 0 of mag
      logic [63:0] raw;     // pass-through or special pattern
      logic        special; // raw is the final result
      logic        last;
   } s1_type;

   // stage 2 to stage 3: left-normalized significand
   typedef struct packed {
      logic        dbl;
      logic        sign;
      logic        zero;
      logic [63:0] norm;    // msb at bit 63
      logic [12:0] x;       // unbiased exponent of msb
      logic [63:0] raw;
      logic        special;
      logic        last;
   } s2_type;

   function automatic logic [5:0] lzc64(input logic [63:0] v);
      logic [5:0] n;
      n = 6'd0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) n = 6'(63 - i);
      end
      return n;
   endfunction

endpackage

FILE: hw/rtl/sample_to_float_converter.sv
// top level: three-stage sample to float conversion pipeline
//  channel | direction | payload
//  req     | in        | req_type sample_word, last_in
//  rsp     | out       | rsp_type float_bits, last_out
//  csr     | in        | 2-bit index, 64-bit data
// requests pass through s1_ff, s2_ff and r_ff in order; one request per cycle sustained while rsp_ready stays high
// stages: decode and swap, leading zero normalize, round and pack
// synchronous reset clears valids and the configuration
// a stalled stage holds; upstream moves into a slot that is empty or being emptied
module sample_to_float_converter (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  stf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output stf_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [63:0]      csr_data
);
   import stf_pkg::*;

   cfg_type cfg_ff;
   s1_type  s1_in, s1_ff;
   s2_type  s2_in, s2_ff;
   rsp_type r_in, r_ff;
   logic    v1_ff, v2_ff, v3_ff;
   logic    en1, en2, en3;

   assign csr_ready = 1'b1;
   assign en3 = !v3_ff || rsp_ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_ready = en1;
   assign rsp_valid = v3_ff;
   assign rsp_data = r_ff;

   stf_decode    u_dec (.req(req_data), .cfg(cfg_ff), .s1(s1_in));
   stf_normalize u_nrm (.s1(s1_ff), .s2(s2_in));
   stf_round     u_rnd (.s2(s2_ff), .rsp(r_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_FMT_SEL:       cfg_ff.fmt_sel <= csr_data[3:0];
               CSR_SWAP_BYTES:    cfg_ff.swap_bytes <= csr_data[0];
               CSR_OUTPUT_DOUBLE: cfg_ff.output_double <= csr_data[0];
               default: ;
            endcase
         end
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) s1_ff <= s1_in;
      if (en2) s2_ff <= s2_in;
      if (en3) r_ff <= r_in;
   end
endmodule

FILE: hw/rtl/stf_decode.sv
// stage 1: sample extraction, byte swap, sign and special float handling
module stf_decode (
   input  stf_pkg::req_type req,
   input  stf_pkg::cfg_type cfg,
   output stf_pkg::s1_type  s1
);
   import stf_pkg::*;

   logic [3:0]  fmt;
   logic [3:0]  nbytes;
   logic [63:0] v, sw, mask;
   logic        is_signed, neg;
   logic [31:0] f;
   logic [63:0] d;

   always_comb begin
      fmt = (cfg.fmt_sel > FMT_S64) ? FMT_F32 : cfg.fmt_sel;
      case (fmt)
         FMT_F64, FMT_U64, FMT_S64: nbytes = 4'd8;
         FMT_U8, FMT_S8:            nbytes = 4'd1;
         FMT_U16, FMT_S16:          nbytes = 4'd2;
         default:                   nbytes = 4'd4;
      endcase
      is_signed = (fmt >= FMT_S8);
      mask = '0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < nbytes) mask[8*i +: 8] = 8'hFF;
      end
      v = req.sample_word & mask;
      sw = '0;
      for (int i = 0; i < 8; i++) begin
         for (int j = 0; j < 8; j++) begin
            if (4'(i) < nbytes && 4'(j) == nbytes - 4'd1 - 4'(i))
               sw[8*j +: 8] = v[8*i +: 8];
         end
      end
      if (cfg.swap_bytes) v = sw;
      f = v[31:0];
      d = v;

      s1 = '0;
      s1.dbl = cfg.output_double;
      s1.last = req.last_in;
      neg = is_signed && v[6'(8*nbytes - 4'd1)];
      if (fmt == FMT_F32) begin
         s1.sign = f[31];
         if (!cfg.output_double) begin
            s1.special = 1'b1; s1.raw = v;
         end else begin
            if (f[30:23] == 8'hFF) begin
               s1.special = 1'b1;
               s1.raw = {f[31], 11'h7FF, f[22:0], 29'd0};
               if (f[22:0] != 0) s1.raw[51] = 1'b1;
            end else if (f[30:23] == 8'd0) begin
               s1.mag = {41'd0, f[22:0]};
               s1.ex = -13'sd149;
            end else begin
               s1.mag = {40'd0, 1'b1, f[22:0]};
               s1.ex = 13'({5'd0, f[30:23]}) - 13'd150;
            end
         end
      end else if (fmt == FMT_F64) begin
         s1.sign = d[63];
         if (cfg.output_double) begin
            s1.special = 1'b1; s1.raw = v;
         end else begin
            if (d[62:52] == 11'h7FF) begin
               s1.special = 1'b1;
               s1.raw = (d[51:0] == 0) ? {32'd0, d[63], 31'h7F800000}
                                       : {32'd0, d[63], 9'h1FF, d[50:29]};
            end else if (d[62:52] == 11'd0) begin
               s1.mag = {12'd0, d[51:0]};
               s1.ex = -13'sd1074;
            end else begin
               s1.mag = {11'd0, 1'b1, d[51:0]};
               s1.ex = 13'({2'd0, d[62:52]}) - 13'd1075;
            end
         end
      end else begin
         s1.sign = neg;
         s1.mag = neg ? ((~v + 64'd1) & mask) : v;
         s1.ex = '0;
      end
   end
endmodule

FILE: hw/rtl/stf_normalize.sv
// stage 2: leading zero count and left normalize
module stf_normalize (
   input  stf_pkg::s1_type s1,
   output stf_pkg::s2_type s2
);
   import stf_pkg::*;

   logic [5:0] lz;

   always_comb begin
      lz = lzc64(s1.mag);
      s2.dbl = s1.dbl;
      s2.sign = s1.sign;
      s2.zero = (s1.mag == 0);
      s2.norm = s1.mag << lz;
      s2.x = s1.ex + 13'(7'd63 - {1'b0, lz});
      s2.raw = s1.raw;
      s2.special = s1.special;
      s2.last = s1.last;
   end
endmodule

FILE: hw/rtl/stf_round.sv
// stage 3: rounding, exponent range handling and packing
module stf_round (
   input  stf_pkg::s2_type  s2,
   output stf_pkg::rsp_type rsp
);
   import stf_pkg::*;

   logic [63:0] sh;
   logic [12:0] x, dsh;
   logic [53:0] keep;
   logic        g, st, up;
   logic [63:0] res;

   always_comb begin
      x = s2.x;
      sh = s2.norm;
      dsh = '0;
      // target subnormal for float32: shift further right
      if (!s2.dbl && $signed(x) < -13'sd126) begin
         dsh = -13'sd126 - x;
         if (dsh > 13'd40) dsh = 13'd40;
         sh = s2.norm >> dsh[5:0];
         if ((s2.norm & ~({64{1'b1}} << dsh[5:0])) != 0) sh[0] = 1'b1;
      end
      if (s2.dbl) begin
         keep = {1'b0, sh[63:11]};
         g = sh[10];
         st = (sh[9:0] != 0);
      end else begin
         keep = {30'd0, sh[63:40]};
         g = sh[39];
         st = (sh[38:0] != 0);
      end
      up = g && (st || keep[0]);
      keep = keep + 54'(up);
      res = '0;
      if (s2.special) begin
         res = s2.raw;
      end else if (s2.zero) begin
         res = s2.dbl ? {s2.sign, 63'd0} : {32'd0, s2.sign, 31'd0};
      end else if (s2.dbl) begin
         if (keep[53]) begin
            keep = keep >> 1; x = x + 13'd1;
         end
         res = {s2.sign, 11'(x + 13'd1023), keep[51:0]};
      end else begin
         if (dsh != 0) begin
            res = {32'd0, s2.sign, 8'd0, 23'd0} | {40'd0, keep[23:0]};
         end else begin
            if (keep[24]) begin
               keep = keep >> 1; x = x + 13'd1;
            end
            if ($signed(x) > 13'sd127)
               res = {32'd0, s2.sign, 31'h7F800000};
            else
               res = {32'd0, s2.sign, 8'(x + 13'd127), keep[22:0]};
         end
      end
      rsp.float_bits = res;
      rsp.last_out = s2.last;
   end
endmodule
